// File: hdl/deq_pkg.sv
// Shared types and constants for the double-ended queue unit.
package deq_pkg;

  // Fixed field widths of the stream payload
  localparam int unsigned OPCODE_W = 3;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  // Cells folded together in one registered reduction group
  localparam int unsigned GROUP_SIZE = 32;

  // Operation codes carried on the slave tuser
  localparam logic [OPCODE_W-1:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_QUERY      = 3'd4;
  localparam logic [OPCODE_W-1:0] OP_CONTAINS   = 3'd5;

  // Result status codes
  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

  // Control sequence of one operation
  typedef enum logic [1:0] {
    S_IDLE,
    S_GROUP,
    S_FOLD,
    S_OUT
  } state_t;

  // Shift and write commands broadcast to every cell
  typedef struct packed {
    logic push_front;
    logic push_back;
    logic pop_front;
    logic pop_back;
  } deq_cmd_t;

endpackage

// File: hdl/double_ended_queue_unit.sv
// Top level of the double-ended queue: cell chain, control sequence and result register.
//
//  channel | direction | tdata                         | tuser
//  s_*     | in        | value                         | opcode
//  m_*     | out       | front, back, element count    | found, status
//
// Each operation runs through the control sequence in order: the transfer in updates the
// cell chain, S_GROUP folds match flags and tail entry per group of 32 cells, S_FOLD
// folds the groups into the result register, and S_OUT offers the result. One item
// is in flight; s_tready stays low until the result transfers out. rst is
// synchronous and empties the queue; entry contents are not cleared.
module double_ended_queue_unit #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
  localparam int unsigned OUT_BITS  = 2 * deq_pkg::VALUE_W + CNT_W,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic                                               s_tvalid,
  output logic                                               s_tready,
  input  logic [deq_pkg::VALUE_W-1:0]                        s_tdata,  // [31:0] value
  input  logic [deq_pkg::OPCODE_W-1:0]                       s_tuser,  // [2:0] opcode
  output logic                                               m_tvalid,
  input  logic                                               m_tready,
  output logic [OUT_W-1:0]  m_tdata,  // front_value, back_value, element_count, zero pad
  output logic [deq_pkg::STATUS_W:0]                         m_tuser   // [0] found, status
);
  import deq_pkg::*;

  state_t                 state;
  state_t                 state_next;
  logic [CNT_W-1:0]       count;
  logic [OPCODE_W-1:0]    op;
  logic [DATA_WIDTH-1:0]  key;
  logic [STATUS_W-1:0]    status;
  logic [VALUE_W-1:0]     front_value;
  logic [VALUE_W-1:0]     back_value;
  logic                   found;

  logic                   accept;
  logic                   full;
  logic                   empty;
  logic                   group_en;
  logic                   fold_en;
  deq_cmd_t               cmd;
  logic [DATA_WIDTH-1:0]  value_dw;

  logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
  logic [DATA_WIDTH-1:0]  cell_tail [DEPTH];
  logic [DEPTH-1:0]       cell_valid;
  logic [DEPTH-1:0]       cell_match;
  logic                   any_match;
  logic [DATA_WIDTH-1:0]  back_data;

  assign accept   = s_tvalid && s_tready;
  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign value_dw = DATA_WIDTH'(s_tdata);

  // Decode the broadcast command for the chain
  always_comb begin
    cmd.push_front = accept && (s_tuser == OP_PUSH_FRONT) && !full;
    cmd.push_back  = accept && (s_tuser == OP_PUSH_BACK) && !full;
    cmd.pop_front  = accept && (s_tuser == OP_POP_FRONT) && !empty;
    cmd.pop_back   = accept && (s_tuser == OP_POP_BACK) && !empty;
  end

  // Cell chain, front at index zero
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_data;
    logic                  left_valid;
    logic [DATA_WIDTH-1:0] right_data;
    logic                  right_valid;

    if (i == 0) begin : g_first
      assign left_data  = value_dw;
      assign left_valid = 1'b1;
    end else begin : g_inner_left
      assign left_data  = cell_data[i-1];
      assign left_valid = cell_valid[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_data  = '0;
      assign right_valid = 1'b0;
    end else begin : g_inner_right
      assign right_data  = cell_data[i+1];
      assign right_valid = cell_valid[i+1];
    end

    deq_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .value       (value_dw),
      .key         (key),
      .left_data   (left_data),
      .left_valid  (left_valid),
      .right_data  (right_data),
      .right_valid (right_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .match       (cell_match[i]),
      .tail_data   (cell_tail[i])
    );
  end

  deq_reduce #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_reduce (
    .clk       (clk),
    .group_en  (group_en),
    .match     (cell_match),
    .tail_data (cell_tail),
    .any_match (any_match),
    .back_data (back_data)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (s_tvalid) state_next = S_GROUP;
      S_GROUP: state_next = S_FOLD;
      S_FOLD:  state_next = S_OUT;
      S_OUT:   if (m_tready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    group_en = 1'b0;
    fold_en  = 1'b0;
    case (state)
      S_IDLE:  s_tready = 1'b1;
      S_GROUP: group_en = 1'b1;
      S_FOLD:  fold_en  = 1'b1;
      S_OUT:   m_tvalid = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Track the element count
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.push_front || cmd.push_back) begin
      count <= count + 1'b1;
    end else if (cmd.pop_front || cmd.pop_back) begin
      count <= count - 1'b1;
    end
  end

  // Capture the operation and its status on transfer in
  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= s_tuser;
      key <= value_dw;
      if ((s_tuser == OP_PUSH_FRONT || s_tuser == OP_PUSH_BACK) && full) begin
        status <= STATUS_FULL;
      end else if ((s_tuser == OP_POP_FRONT || s_tuser == OP_POP_BACK) && empty) begin
        status <= STATUS_EMPTY;
      end else begin
        status <= STATUS_OK;
      end
    end
  end

  // Register the result fields
  always_ff @(posedge clk) begin
    if (fold_en) begin
      front_value <= cell_valid[0] ? VALUE_W'(cell_data[0]) : '0;
      back_value  <= VALUE_W'(back_data);
      found       <= any_match && (op == OP_CONTAINS);
    end
  end

  assign m_tdata = OUT_W'({count, back_value, front_value});
  assign m_tuser = {status, found};

endmodule

// File: hdl/deq_cell.sv
// One storage cell of the queue chain: holds an entry and shifts with its neighbors.
module deq_cell #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                    clk,
  input  logic                    rst,
  input  deq_pkg::deq_cmd_t       cmd,
  input  logic [DATA_WIDTH-1:0]   value,
  input  logic [DATA_WIDTH-1:0]   key,
  input  logic [DATA_WIDTH-1:0]   left_data,
  input  logic                    left_valid,
  input  logic [DATA_WIDTH-1:0]   right_data,
  input  logic                    right_valid,
  output logic [DATA_WIDTH-1:0]   data,
  output logic                    valid,
  output logic                    match,
  output logic [DATA_WIDTH-1:0]   tail_data
);
  import deq_pkg::*;

  logic tail;

  assign tail      = valid && !right_valid;
  assign match     = valid && (data == key);
  assign tail_data = tail ? data : '0;

  // Occupancy: shift toward the back, shift toward the front, fill, or drop the tail
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (cmd.push_front) begin
      valid <= left_valid;
    end else if (cmd.pop_front) begin
      valid <= right_valid;
    end else if (cmd.push_back && !valid && left_valid) begin
      valid <= 1'b1;
    end else if (cmd.pop_back && tail) begin
      valid <= 1'b0;
    end
  end

  // Entry contents follow the same moves
  always_ff @(posedge clk) begin
    if (cmd.push_front) begin
      data <= left_data;
    end else if (cmd.pop_front) begin
      data <= right_data;
    end else if (cmd.push_back && !valid && left_valid) begin
      data <= value;
    end
  end

endmodule

// File: hdl/deq_reduce.sv
// Two-level reduction of the cells' match flags and tail entry.
module deq_reduce #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  group_en,
  input  logic [DEPTH-1:0]      match,
  input  logic [DATA_WIDTH-1:0] tail_data [DEPTH],
  output logic                  any_match,
  output logic [DATA_WIDTH-1:0] back_data
);
  import deq_pkg::*;

  localparam int unsigned NGRP = (DEPTH + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [NGRP-1:0]       grp_match;
  logic [DATA_WIDTH-1:0] grp_back [NGRP];
  logic [NGRP-1:0]       grp_match_next;
  logic [DATA_WIDTH-1:0] grp_back_next [NGRP];

  // Fold each group of cells; only one cell holds the tail, so OR selects it
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_match_next[g] = 1'b0;
      grp_back_next[g]  = '0;
      for (int k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < DEPTH) begin
          grp_match_next[g] = grp_match_next[g] | match[g * GROUP_SIZE + k];
          grp_back_next[g]  = grp_back_next[g] | tail_data[g * GROUP_SIZE + k];
        end
      end
    end
  end

  // Hold group results for the final fold
  always_ff @(posedge clk) begin
    if (group_en) begin
      grp_match <= grp_match_next;
      for (int g = 0; g < NGRP; g++) begin
        grp_back[g] <= grp_back_next[g];
      end
    end
  end

  // Fold the groups
  always_comb begin
    any_match = |grp_match;
    back_data = '0;
    for (int g = 0; g < NGRP; g++) begin
      back_data = back_data | grp_back[g];
    end
  end

endmodule

// File: hdl/deq_checker.sv
// Port-level assertions for the double-ended queue unit, with their bind.
module deq_checker #(
  parameter int unsigned DEPTH      = 16,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1),
  localparam int unsigned OUT_BITS  = 2 * deq_pkg::VALUE_W + CNT_W,
  localparam int unsigned OUT_W     = ((OUT_BITS + 7) / 8) * 8
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [OUT_W-1:0]              m_tdata,
  input logic [deq_pkg::STATUS_W:0]    m_tuser
);
  import deq_pkg::*;

  logic [CNT_W-1:0]    cnt;
  logic [STATUS_W-1:0] stat;
  logic                fnd;
  logic [VALUE_W-1:0]  front;
  logic [VALUE_W-1:0]  back;

  assign front = m_tdata[VALUE_W-1:0];
  assign back  = m_tdata[2*VALUE_W-1:VALUE_W];
  assign cnt   = m_tdata[2*VALUE_W +: CNT_W];
  assign fnd   = m_tuser[0];
  assign stat  = m_tuser[STATUS_W:1];

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // Count stays within capacity
  a_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> cnt <= CNT_W'(DEPTH))
    else $error("element count beyond capacity");

  // Dropped push only when full, ignored pop only when empty
  a_status: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (stat != STATUS_FULL || cnt == CNT_W'(DEPTH)) &&
                 (stat != STATUS_EMPTY || cnt == '0))
    else $error("status disagrees with element count");

  // Empty queue reports zero ends and nothing found
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && cnt == '0 |-> front == '0 && back == '0 && !fnd)
    else $error("empty queue reports data");

  // Input is taken only while no result is pending
  a_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready)
    else $error("input taken while result pending");

endmodule

bind double_ended_queue_unit deq_checker #(
  .DEPTH (DEPTH)
) u_deq_checker (.*);

// File: tb/sv/double_ended_queue_unit_tb.sv
// Self-checking stream testbench for the double-ended queue unit.
module double_ended_queue_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int unsigned DEPTH     = 16;
  localparam int unsigned OUT_W     = 72;
  localparam int unsigned MAX_PRINT = 100;

  // Unused opcodes behave as query
  localparam logic [OPCODE_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OPCODE_W-1:0] OP_SPARE_7 = 3'd7;

  // One result as seen on the master side
  typedef struct packed {
    logic [VALUE_W-1:0]  front;
    logic [VALUE_W-1:0]  back;
    logic [4:0]          count;
    logic                found;
    logic [STATUS_W-1:0] status;
  } deq_view_t;

  logic                clk      = 1'b0;
  logic                rst      = 1'b1;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [VALUE_W-1:0]  s_tdata  = '0;
  logic [OPCODE_W-1:0] s_tuser  = OP_QUERY;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OUT_W-1:0]    m_tdata;
  logic [STATUS_W:0]   m_tuser;

  // Deque mirror: ring of slots, head index and element count
  logic [VALUE_W-1:0] mirror_slots [DEPTH];
  int                 mirror_head  = 0;
  int                 mirror_count = 0;

  deq_view_t views_due [$];
  deq_view_t got_view;
  deq_view_t want_view;

  int error_count = 0;
  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_cycles = 0;

  double_ended_queue_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #1 clk = ~clk;

  // Abort a hung run
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    if (error_count < MAX_PRINT)
      $display("%0t: mismatch %s got %h want %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Apply one operation to the mirror and return the result it must produce
  function automatic deq_view_t step_deque_mirror(input logic [OPCODE_W-1:0] op,
                                                  input logic [VALUE_W-1:0] val);
    deq_view_t view;
    view = '0;
    case (op)
      OP_PUSH_FRONT: begin
        if (mirror_count == DEPTH) begin
          view.status = STATUS_FULL;
        end else begin
          mirror_head = (mirror_head + DEPTH - 1) % DEPTH;
          mirror_slots[mirror_head] = val;
          mirror_count++;
        end
      end
      OP_PUSH_BACK: begin
        if (mirror_count == DEPTH) begin
          view.status = STATUS_FULL;
        end else begin
          mirror_slots[(mirror_head + mirror_count) % DEPTH] = val;
          mirror_count++;
        end
      end
      OP_POP_FRONT: begin
        if (mirror_count == 0) begin
          view.status = STATUS_EMPTY;
        end else begin
          mirror_head = (mirror_head + 1) % DEPTH;
          mirror_count--;
        end
      end
      OP_POP_BACK: begin
        if (mirror_count == 0) view.status = STATUS_EMPTY;
        else mirror_count--;
      end
      OP_CONTAINS: begin
        for (int i = 0; i < mirror_count; i++)
          if (mirror_slots[(mirror_head + i) % DEPTH] == val) view.found = 1'b1;
      end
      default: ;
    endcase
    if (mirror_count != 0) begin
      view.front = mirror_slots[mirror_head];
      view.back  = mirror_slots[(mirror_head + mirror_count - 1) % DEPTH];
    end
    view.count = 5'(mirror_count);
    return view;
  endfunction

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles = hold_cycles - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Compare every result transfer against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_view.front  = m_tdata[VALUE_W-1:0];
      got_view.back   = m_tdata[2*VALUE_W-1:VALUE_W];
      got_view.count  = m_tdata[2*VALUE_W+4:2*VALUE_W];
      got_view.found  = m_tuser[0];
      got_view.status = m_tuser[STATUS_W:1];
      if (views_due.size() == 0) begin
        report_mismatch("unexpected result, front", got_view.front, '0);
      end else begin
        want_view = views_due.pop_front();
        if (got_view.front !== want_view.front)
          report_mismatch("front_value", got_view.front, want_view.front);
        if (got_view.back !== want_view.back)
          report_mismatch("back_value", got_view.back, want_view.back);
        if (got_view.count !== want_view.count)
          report_mismatch("element_count", 32'(got_view.count), 32'(want_view.count));
        if (got_view.found !== want_view.found)
          report_mismatch("found", 32'(got_view.found), 32'(want_view.found));
        if (got_view.status !== want_view.status)
          report_mismatch("status", 32'(got_view.status), 32'(want_view.status));
      end
    end
  end

  // Offer one operation, idling first at random; record it once it transfers
  task automatic send_item(input logic [OPCODE_W-1:0] op, input logic [VALUE_W-1:0] val);
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= val;
    s_tuser  <= op;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    views_due.push_back(step_deque_mirror(op, val));
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic wait_drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (views_due.size() != 0) @(posedge clk);
  endtask

  // Pick an operation with the given push and pop weights, plus a value
  task automatic send_random_item(input int push_w, input int pop_w);
    logic [OPCODE_W-1:0] op;
    logic [VALUE_W-1:0]  val;
    int                  r;
    r = $urandom_range(99);
    if (r < push_w) op = $urandom_range(1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
    else if (r < push_w + pop_w) op = $urandom_range(1) ? OP_POP_FRONT : OP_POP_BACK;
    else begin
      r = $urandom_range(9);
      if (r < 5) op = OP_CONTAINS;
      else if (r < 8) op = OP_QUERY;
      else if (r == 8) op = OP_SPARE_6;
      else op = OP_SPARE_7;
    end
    // Mix extremes, small repeated values and full-range values
    case ($urandom_range(9))
      0: val = '0;
      1: val = '1;
      2, 3: val = $urandom_range(15);
      default: val = $urandom;
    endcase
    // Search for a stored element half of the time
    if (op == OP_CONTAINS && mirror_count > 0 && $urandom_range(1))
      val = mirror_slots[(mirror_head + $urandom_range(mirror_count - 1)) % DEPTH];
    send_item(op, val);
  endtask

  // Empty-queue cases, extreme values, fill to full and push on full
  task automatic test_directed();
    idle_pct  = 0;
    stall_pct = 0;
    send_item(OP_POP_FRONT, 32'h0);
    send_item(OP_POP_BACK, 32'h0);
    send_item(OP_CONTAINS, 32'h0);
    send_item(OP_SPARE_6, 32'h0);
    send_item(OP_PUSH_FRONT, 32'h0000_0000);
    send_item(OP_PUSH_BACK, 32'hFFFF_FFFF);
    send_item(OP_CONTAINS, 32'hFFFF_FFFF);
    send_item(OP_CONTAINS, 32'h1234_5678);
    send_item(OP_SPARE_7, 32'hFFFF_FFFF);
    for (int i = 0; i < DEPTH - 2; i++)
      send_item((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, 32'h1111_1111 * (i + 1) ^ 32'h8000_0001);
    send_item(OP_PUSH_FRONT, 32'hDEAD_BEEF);
    send_item(OP_PUSH_BACK, 32'hCAFE_F00D);
    send_item(OP_CONTAINS, 32'h1111_1111 * 6 ^ 32'h8000_0001);
    send_item(OP_POP_FRONT, 32'h0);
    send_item(OP_POP_BACK, 32'h0);
    send_item(OP_QUERY, 32'h0);
    wait_drain();
  endtask

  // Random operations, alternating between filling and draining the queue
  task automatic test_random(input int n_items, input int idle, input int stall);
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < n_items; i++) begin
      if ((i / 40) % 2 == 0) send_random_item(65, 20);
      else send_random_item(20, 65);
    end
    wait_drain();
  endtask

  // Hold the receiver off for a long stretch while items keep coming
  task automatic test_hold_off();
    idle_pct    = 0;
    stall_pct   = 0;
    hold_cycles = 300;
    for (int i = 0; i < 24; i++) send_random_item(70, 15);
    wait_drain();
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random(225, 0, 0);
    test_random(225, 52, 0);
    test_hold_off();
    test_random(225, 0, 52);
    test_random(225, 15, 15);
    repeat (20) @(posedge clk);
    if (views_due.size() != 0) report_mismatch("results missing", views_due.size(), 0);
    if (error_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
